FILE: rtl/snaprx_pkg.sv
`default_nettype none

package snaprx_pkg;

   typedef logic [7:0] byte_type;

   // Status fields that travel with every result beat.
   typedef struct packed {
      logic     busy;
      byte_type dest;
      byte_type sender;
      logic [4:0] length;
   } status_type;

   // Request operations.
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_SYNC       = 3'd0;
   localparam logic [2:0] REG_ADDR_COUNT = 3'd1;
   localparam logic [2:0] REG_ADDR0      = 3'd2;
   localparam logic [2:0] REG_ADDR1      = 3'd3;
   localparam logic [2:0] REG_ADDR2      = 3'd4;
   localparam logic [2:0] REG_ADDR3      = 3'd5;

   localparam byte_type   SYNC_RESET        = 8'd84;
   localparam logic [2:0] MAX_OWN_ADDRESSES = 3'd4;

   // Header checks and reply header codes.
   localparam byte_type   HDR2_MASK  = 8'hFC;
   localparam byte_type   HDR2_VALUE = 8'h50;
   localparam byte_type   HDR1_MASK  = 8'hF0;
   localparam byte_type   HDR1_VALUE = 8'h30;
   localparam byte_type   HDR2_ACK   = 8'h52;
   localparam byte_type   HDR2_NAK   = 8'h53;
   localparam logic [1:0] ACK_REQUEST = 2'b01;

   // Dallas CRC-8 (reflected 0x8C): contribution of each set bit of acc ^ data.
   localparam byte_type CRC_BITS [8] = '{8'h5e, 8'hbc, 8'h61, 8'hc2,
                                         8'h9d, 8'h23, 8'h46, 8'h8c};

   function automatic byte_type crc8_step(input byte_type acc, input byte_type data);
      byte_type x;
      byte_type r;
      x = acc ^ data;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (x[i]) r = r ^ CRC_BITS[i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/snap_ring_packet_receiver_unit.sv
`default_nettype none

// SNAP ring-node receiver. Each request carries one operation: a received ring
// byte, a release of the packet lock, or a read of a stored payload byte. A
// request yields one or more result beats, one per cycle while rsp_tready is
// high: a single beat with send_valid low when nothing is to be sent, six
// beats for an ACK/NAK frame, four (header) or one (each later byte) for a
// forwarded packet, and eight zero beats on a header error. The next request
// is taken in the cycle its last beat leaves. Payload bytes live in a
// synchronous payload RAM of PAYLOAD_DEPTH bytes whose read data is
// registered when the read request is accepted.
module snap_ring_packet_receiver_unit #(
   parameter int PAYLOAD_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] line_byte, [11:8] read_index, [15:12] zero
   input  wire logic [15:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] send_byte, [8] packet_ready, [16:9] dest_seen, [24:17] sender_seen,
   // [29:25] payload_count, [37:30] read_value, [39:38] zero
   output logic [39:0]      rsp_tdata,
   // [0] send_valid
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam logic [4:0] DEPTH5 = 5'(PAYLOAD_DEPTH);

   // Receiver phases.
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_SYNC      = 4'd1;
   localparam logic [3:0] PH_HDR2      = 4'd2;
   localparam logic [3:0] PH_HDR1      = 4'd3;
   localparam logic [3:0] PH_DEST      = 4'd4;
   localparam logic [3:0] PH_DATA      = 4'd5;
   localparam logic [3:0] PH_CHECK     = 4'd6;
   localparam logic [3:0] PH_PASS_SRC  = 4'd7;
   localparam logic [3:0] PH_PASS_DATA = 4'd8;

   // Configuration registers.
   snaprx_pkg::byte_type sync_ff;
   logic [2:0]           addr_count_ff;
   snaprx_pkg::byte_type own_addr_ff [4];

   // Receiver state.
   logic [3:0]           phase_ff, phase_in;
   snaprx_pkg::byte_type crc_ff, crc_in;
   snaprx_pkg::byte_type hdr_two_ff, hdr_two_in;
   snaprx_pkg::byte_type hdr_one_ff, hdr_one_in;
   snaprx_pkg::byte_type dest_ff, dest_in;
   snaprx_pkg::byte_type sender_ff, sender_in;
   logic [4:0]           length_ff, length_in;
   logic [4:0]           fill_ff, fill_in;
   logic                 ack_ff, ack_in;
   logic                 busy_ff, busy_in;
   logic                 aborted_ff, aborted_in;

   // Result stage: the frame of the request being sent out.
   logic                   job_valid_ff, job_valid_in;
   snaprx_pkg::byte_type   job_bytes_ff [8];
   logic [2:0]             job_last_ff;
   logic                   job_send_ff;
   logic [2:0]             job_beat_ff, job_beat_in;
   snaprx_pkg::status_type job_status_ff;
   logic                   rd_ok_ff;

   // Payload RAM.
   snaprx_pkg::byte_type payload_mem [PAYLOAD_DEPTH];
   snaprx_pkg::byte_type rd_data_ff;

   logic                 accept;
   logic [1:0]           op;
   snaprx_pkg::byte_type c;
   logic [3:0]           rd_index;
   logic                 rd_ok;
   logic                 rd_en;
   logic                 out_done;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;

   snaprx_pkg::byte_type frame [8];
   logic [3:0]           frame_n;

   logic                 is_own;
   logic [2:0]           addr_limit;
   logic                 hdr2_ok;
   logic                 hdr1_ok;
   logic [4:0]           len_clamped;
   logic [4:0]           fill_next;
   logic                 crc_match;
   snaprx_pkg::byte_type reply_hdr;
   snaprx_pkg::byte_type reply_to;
   snaprx_pkg::byte_type reply_c1, reply_c2, reply_c3, reply_c4;
   snaprx_pkg::byte_type sync_crc;
   logic                 csr_write;

   assign op       = req_tuser;
   assign c        = req_tdata[7:0];
   assign rd_index = req_tdata[11:8];

   // Handshakes: a new request is taken when no frame is pending or the last beat of the current frame is taken.
   assign out_done   = job_valid_ff && rsp_tready && (job_beat_ff == job_last_ff);
   assign req_tready = !job_valid_ff || out_done;
   assign accept     = req_tvalid && req_tready;

   assign rd_ok = (op == snaprx_pkg::OP_READ) && ({1'b0, rd_index} < DEPTH5);
   assign rd_en = accept && rd_ok;

   // Own-address match over the valid part of the address list.
   always_comb begin
      addr_limit = (addr_count_ff > snaprx_pkg::MAX_OWN_ADDRESSES) ?
                   snaprx_pkg::MAX_OWN_ADDRESSES : addr_count_ff;
      is_own = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if ((3'(i) < addr_limit) && (own_addr_ff[i] == c)) is_own = 1'b1;
      end
   end

   assign hdr2_ok     = (c & snaprx_pkg::HDR2_MASK) == snaprx_pkg::HDR2_VALUE;
   assign hdr1_ok     = (c & snaprx_pkg::HDR1_MASK) == snaprx_pkg::HDR1_VALUE;
   assign len_clamped = ({1'b0, c[3:0]} > DEPTH5) ? DEPTH5 : {1'b0, c[3:0]};
   assign fill_next   = fill_ff + 5'd1;
   assign crc_match   = (c == crc_ff);
   assign sync_crc    = snaprx_pkg::crc8_step(8'h00, c);

   // Reply frame: NAK to the incoming sender while busy, else ACK/NAK after the check.
   always_comb begin
      if (phase_ff == PH_DEST) begin
         reply_hdr = snaprx_pkg::HDR2_NAK;
         reply_to  = c;
      end else begin
         reply_hdr = crc_match ? snaprx_pkg::HDR2_ACK : snaprx_pkg::HDR2_NAK;
         reply_to  = sender_ff;
      end
   end

   assign reply_c1 = snaprx_pkg::crc8_step(8'h00, reply_hdr);
   assign reply_c2 = snaprx_pkg::crc8_step(reply_c1, snaprx_pkg::HDR1_VALUE);
   assign reply_c3 = snaprx_pkg::crc8_step(reply_c2, reply_to);
   assign reply_c4 = snaprx_pkg::crc8_step(reply_c3, dest_ff);

   // Next receiver state and the frame this request produces.
   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      hdr_two_in = hdr_two_ff;
      hdr_one_in = hdr_one_ff;
      dest_in    = dest_ff;
      sender_in  = sender_ff;
      length_in  = length_ff;
      fill_in    = fill_ff;
      ack_in     = ack_ff;
      busy_in    = busy_ff;
      aborted_in = aborted_ff;
      mem_we     = 1'b0;
      mem_waddr  = fill_ff[AW-1:0];
      frame_n    = 4'd0;
      for (int i = 0; i < 8; i++) frame[i] = 8'h00;

      if (accept) begin
         case (op)
            snaprx_pkg::OP_BYTE: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     if (c == sync_ff) begin
                        phase_in   = PH_SYNC;
                        aborted_in = 1'b0;
                     end
                  end
                  PH_SYNC: begin
                     hdr_two_in = c;
                     if (!hdr2_ok) begin
                        frame_n  = aborted_ff ? 4'd0 : 4'd8;
                        ack_in   = 1'b0;
                        busy_in  = 1'b0;
                        phase_in = PH_IDLE;
                     end else begin
                        ack_in   = (c[1:0] == snaprx_pkg::ACK_REQUEST);
                        crc_in   = sync_crc;
                        phase_in = PH_HDR2;
                     end
                  end
                  PH_HDR2: begin
                     hdr_one_in = c;
                     if (!hdr1_ok) begin
                        frame_n  = aborted_ff ? 4'd0 : 4'd8;
                        ack_in   = 1'b0;
                        busy_in  = 1'b0;
                        phase_in = PH_IDLE;
                     end else begin
                        length_in = len_clamped;
                        crc_in    = snaprx_pkg::crc8_step(crc_ff, c);
                        phase_in  = PH_HDR1;
                     end
                  end
                  PH_HDR1: begin
                     if (!is_own) begin
                        // Not for this node: pass the header on unchanged.
                        frame[0] = sync_ff;
                        frame[1] = hdr_two_ff;
                        frame[2] = hdr_one_ff;
                        frame[3] = c;
                        frame_n  = 4'd4;
                        ack_in   = 1'b0;
                        phase_in = PH_PASS_SRC;
                     end else begin
                        dest_in  = c;
                        crc_in   = snaprx_pkg::crc8_step(crc_ff, c);
                        phase_in = PH_DEST;
                     end
                  end
                  PH_DEST: begin
                     if (busy_ff) begin
                        frame[0]   = sync_ff;
                        frame[1]   = reply_hdr;
                        frame[2]   = snaprx_pkg::HDR1_VALUE;
                        frame[3]   = reply_to;
                        frame[4]   = dest_ff;
                        frame[5]   = reply_c4;
                        frame_n    = 4'd6;
                        crc_in     = reply_c4;
                        ack_in     = 1'b0;
                        aborted_in = 1'b1;
                        phase_in   = PH_IDLE;
                     end else begin
                        sender_in = c;
                        fill_in   = 5'd0;
                        crc_in    = snaprx_pkg::crc8_step(crc_ff, c);
                        phase_in  = (length_ff == 5'd0) ? PH_CHECK : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     mem_we  = (fill_ff < DEPTH5);
                     fill_in = fill_next;
                     crc_in  = snaprx_pkg::crc8_step(crc_ff, c);
                     if (fill_next >= length_ff) phase_in = PH_CHECK;
                  end
                  PH_CHECK: begin
                     if (crc_match) busy_in = 1'b1;
                     if (ack_ff) begin
                        frame[0] = sync_ff;
                        frame[1] = reply_hdr;
                        frame[2] = snaprx_pkg::HDR1_VALUE;
                        frame[3] = reply_to;
                        frame[4] = dest_ff;
                        frame[5] = reply_c4;
                        frame_n  = 4'd6;
                        crc_in   = reply_c4;
                        ack_in   = 1'b0;
                     end
                     phase_in = PH_IDLE;
                  end
                  PH_PASS_SRC: begin
                     frame[0]  = c;
                     frame_n   = 4'd1;
                     length_in = length_ff + 5'd1;
                     phase_in  = PH_PASS_DATA;
                  end
                  PH_PASS_DATA: begin
                     frame[0] = c;
                     frame_n  = 4'd1;
                     if (length_ff > 5'd1) length_in = length_ff - 5'd1;
                     else phase_in = PH_IDLE;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            snaprx_pkg::OP_RELEASE: begin
               busy_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Result stage beat control.
   always_comb begin
      job_valid_in = job_valid_ff;
      job_beat_in  = job_beat_ff;
      if (job_valid_ff && rsp_tready) begin
         if (job_beat_ff == job_last_ff) job_valid_in = 1'b0;
         else job_beat_in = job_beat_ff + 3'd1;
      end
      if (accept) begin
         job_valid_in = 1'b1;
         job_beat_in  = 3'd0;
      end
   end

   // Control and receiver state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         crc_ff       <= '0;
         hdr_two_ff   <= '0;
         hdr_one_ff   <= '0;
         dest_ff      <= '0;
         sender_ff    <= '0;
         length_ff    <= '0;
         fill_ff      <= '0;
         ack_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         aborted_ff   <= 1'b0;
         job_valid_ff <= 1'b0;
         job_beat_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         hdr_two_ff   <= hdr_two_in;
         hdr_one_ff   <= hdr_one_in;
         dest_ff      <= dest_in;
         sender_ff    <= sender_in;
         length_ff    <= length_in;
         fill_ff      <= fill_in;
         ack_ff       <= ack_in;
         busy_ff      <= busy_in;
         aborted_ff   <= aborted_in;
         job_valid_ff <= job_valid_in;
         job_beat_ff  <= job_beat_in;
      end
   end

   // Frame payload of the result stage, loaded when a request is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 8; i++) job_bytes_ff[i] <= frame[i];
         job_last_ff   <= (frame_n == 4'd0) ? 3'd0 : 3'(frame_n - 4'd1);
         job_send_ff   <= (frame_n != 4'd0);
         job_status_ff <= '{busy: busy_in, dest: dest_in, sender: sender_in,
                            length: length_in};
         rd_ok_ff      <= rd_ok;
      end
   end

   // Payload RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) payload_mem[mem_waddr] <= c;
      if (rd_en) rd_data_ff <= payload_mem[rd_index[AW-1:0]];
   end

   // Result channel.
   assign rsp_tvalid = job_valid_ff;
   assign rsp_tuser  = job_send_ff;
   assign rsp_tlast  = (job_beat_ff == job_last_ff);
   assign rsp_tdata  = {2'b00,
                        rd_ok_ff ? rd_data_ff : 8'h00,
                        job_status_ff.length,
                        job_status_ff.sender,
                        job_status_ff.dest,
                        job_status_ff.busy,
                        job_bytes_ff[job_beat_ff]};

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= snaprx_pkg::SYNC_RESET;
         addr_count_ff <= '0;
         for (int i = 0; i < 4; i++) own_addr_ff[i] <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            snaprx_pkg::REG_SYNC:       sync_ff        <= csr_pwdata[7:0];
            snaprx_pkg::REG_ADDR_COUNT: addr_count_ff  <= csr_pwdata[2:0];
            snaprx_pkg::REG_ADDR0:      own_addr_ff[0] <= csr_pwdata[7:0];
            snaprx_pkg::REG_ADDR1:      own_addr_ff[1] <= csr_pwdata[7:0];
            snaprx_pkg::REG_ADDR2:      own_addr_ff[2] <= csr_pwdata[7:0];
            snaprx_pkg::REG_ADDR3:      own_addr_ff[3] <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         snaprx_pkg::REG_SYNC:       csr_prdata = {24'h0, sync_ff};
         snaprx_pkg::REG_ADDR_COUNT: csr_prdata = {29'h0, addr_count_ff};
         snaprx_pkg::REG_ADDR0:      csr_prdata = {24'h0, own_addr_ff[0]};
         snaprx_pkg::REG_ADDR1:      csr_prdata = {24'h0, own_addr_ff[1]};
         snaprx_pkg::REG_ADDR2:      csr_prdata = {24'h0, own_addr_ff[2]};
         snaprx_pkg::REG_ADDR3:      csr_prdata = {24'h0, own_addr_ff[3]};
         default:                    csr_prdata = 32'h0;
      endcase
   end

endmodule

`default_nettype wire
